// ===== rtl/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared widths, packed-word layouts and elaboration-time helper functions
// for the button debouncer with hold events.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int TICK_W      = 16;
    localparam int TIMEOUT_W   = 8;
    localparam int CODE_W      = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 8;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIMEOUT     = 1'd1;

    localparam logic [TIMEOUT_W-1:0] DEBOUNCE_TIMEOUT_RST = 8'd10;
    localparam logic [TIMEOUT_W-1:0] HOLD_TIMEOUT_RST     = 8'd50;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic [CODE_W-1:0] button_state;
    } step_result_t;

    // Number of trailing zero bits of a skip value in the range 1 to 256.
    function automatic int trailing_zeros(input int unsigned v);
        int n;
        n = 0;
        for (int i = 0; i < 9; i++) begin
            if (n == i && v[i] == 1'b0) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // Multiplicative inverse of an odd value modulo 2**TICK_W.
    // Each Newton step doubles the number of correct low bits.
    function automatic logic [TICK_W-1:0] odd_inverse(input logic [TICK_W-1:0] d);
        logic [TICK_W-1:0] x;
        logic [TICK_W-1:0] dx;
        x = d;
        for (int i = 0; i < 4; i++) begin
            dx = TICK_W'(d * x);
            x  = TICK_W'(x * TICK_W'(16'd2 - dx));
        end
        return x;
    endfunction

endpackage

// ===== rtl/button_debounce_hold_events.sv =====
// ----------------------------------------------------------------------------
// button_debounce_hold_events
// Push-button debouncer with pressed, released, held, repeat and kept-up
// events, one result word for every sample word.
// ----------------------------------------------------------------------------
// Each sample word carries the button level and a free-running tick count and
// yields exactly one result word with an event code and the state after the
// step. A new word is taken every clock cycle while the output is not stalled;
// a result passes through the input register and then the result register,
// and the state update itself is a step of the debounce machine, registered
// as the result register is loaded. The input side keeps taking words while a
// finished result waits on the output, until both registers are full. Timeouts
// are written through the configuration channel, which is always ready, and
// should only change while no sample is in flight.
module button_debounce_hold_events
    import bde_pkg::*;
#(
    parameter int HOLD_CHECK_SKIP = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // level[0], tick_count[16:1], zero[23:17]

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // event_code[2:0], button_state[5:3], zero[7:6]

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TIMEOUT_W-1:0]   cfg_data
);

    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic                 in_qual_reg;
    logic                 out_valid_reg;
    step_result_t         out_result_reg;
    logic [TIMEOUT_W-1:0] debounce_timeout_reg;
    logic [TIMEOUT_W-1:0] hold_timeout_reg;

    logic                 s_fire;
    logic                 step_en;
    logic                 tick_qualified;
    step_result_t         step_result;

    assign step_en   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_en;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    bde_tick_qual #(
        .HOLD_CHECK_SKIP (HOLD_CHECK_SKIP)
    ) u_tick_qual (
        .tick_count (s_tdata[TICK_W:1]),
        .qualified  (tick_qualified)
    );

    bde_fsm u_fsm (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (step_en),
        .level            (in_level_reg),
        .qualified        (in_qual_reg),
        .debounce_timeout (debounce_timeout_reg),
        .hold_timeout     (hold_timeout_reg),
        .result           (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            in_level_reg <= s_tdata[0];
            in_qual_reg  <= tick_qualified;
        end
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            debounce_timeout_reg <= DEBOUNCE_TIMEOUT_RST;
            hold_timeout_reg     <= HOLD_TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE_TIMEOUT: debounce_timeout_reg <= cfg_data;
                CFG_HOLD_TIMEOUT:     hold_timeout_reg     <= cfg_data;
                default:              debounce_timeout_reg <= debounce_timeout_reg;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg.button_state, out_result_reg.event_code};

endmodule

// ===== rtl/bde_tick_qual.sv =====
// ----------------------------------------------------------------------------
// bde_tick_qual
// Flags a tick count that is a whole multiple of the hold check skip.
// ----------------------------------------------------------------------------
module bde_tick_qual
    import bde_pkg::*;
#(
    parameter int HOLD_CHECK_SKIP = 16
)
(
    input  logic [TICK_W-1:0] tick_count,
    output logic              qualified
);

    // The skip is split into a power of two and an odd factor. An odd
    // divisor is tested with the modular inverse: n is a multiple of d
    // exactly when n * inv(d) mod 2**16 does not exceed (2**16 - 1) / d.
    localparam int SKIP_TZ  = trailing_zeros(HOLD_CHECK_SKIP);
    localparam int SKIP_ODD = HOLD_CHECK_SKIP >> SKIP_TZ;
    localparam logic [TICK_W-1:0] SKIP_INV   = odd_inverse(TICK_W'(SKIP_ODD));
    localparam logic [TICK_W-1:0] SKIP_LIMIT = TICK_W'(int'(TICK_MAX) / SKIP_ODD);
    localparam logic [TICK_W-1:0] LOW_MASK   = TICK_W'((32'd1 << SKIP_TZ) - 32'd1);

    logic [TICK_W-1:0] tick_odd;
    logic [TICK_W-1:0] product;

    // Only the product modulo 2**16 matters for the test.
    assign tick_odd  = tick_count >> SKIP_TZ;
    assign product   = tick_odd * SKIP_INV;
    assign qualified = ((tick_count & LOW_MASK) == '0)
                       && (product <= SKIP_LIMIT);

endmodule

// ===== rtl/bde_fsm.sv =====
// ----------------------------------------------------------------------------
// bde_fsm
// Six-state debounce and hold machine with its shared stability counter.
// ----------------------------------------------------------------------------
module bde_fsm
    import bde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 level,
    input  logic                 qualified,
    input  logic [TIMEOUT_W-1:0] debounce_timeout,
    input  logic [TIMEOUT_W-1:0] hold_timeout,
    output step_result_t         result
);

    typedef enum logic [CODE_W-1:0] {
        MODE_UP          = 3'd0,
        MODE_KEPT_UP     = 3'd1,
        MODE_BOUNCE_DOWN = 3'd2,
        MODE_DOWN        = 3'd3,
        MODE_HELD        = 3'd4,
        MODE_BOUNCE_UP   = 3'd5
    } mode_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_HELD     = 3'd3,
        EV_HOLDING  = 3'd4,
        EV_KEPT_UP  = 3'd5
    } event_t;

    logic [CODE_W-1:0]    mode_reg;
    logic [CODE_W-1:0]    mode_next;
    logic [TIMEOUT_W-1:0] count_reg;
    logic [TIMEOUT_W-1:0] count_next;
    logic                 prev_level_reg;
    event_t               event_next;

    logic [TIMEOUT_W-1:0] count_bump;
    logic [TIMEOUT_W-1:0] count_hold;
    logic [TIMEOUT_W-1:0] count_bounce;
    logic [TIMEOUT_W-1:0] count_down;
    logic                 run_down;

    assign count_bump   = (count_reg == '1) ? count_reg : count_reg + TIMEOUT_W'(1);
    assign count_hold   = qualified ? count_bump : count_reg;
    assign count_bounce = (level == prev_level_reg) ? count_bump : '0;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        event_next = EV_NONE;
        run_down   = 1'b0;
        count_down = count_reg;

        case (mode_reg)
            MODE_UP:
            begin
                if (level) begin
                    mode_next  = MODE_BOUNCE_DOWN;
                    count_next = '0;
                    event_next = EV_PRESSED;
                end else if (count_hold >= hold_timeout) begin
                    mode_next  = MODE_KEPT_UP;
                    count_next = '0;
                    event_next = EV_KEPT_UP;
                end else begin
                    count_next = count_hold;
                end
            end
            MODE_KEPT_UP:
            begin
                if (level) begin
                    mode_next  = MODE_BOUNCE_DOWN;
                    count_next = '0;
                    event_next = EV_PRESSED;
                end
            end
            MODE_BOUNCE_DOWN, MODE_BOUNCE_UP:
            begin
                if (count_bounce >= debounce_timeout) begin
                    if (mode_reg == MODE_BOUNCE_DOWN) begin
                        // A settled press goes through the down check in the
                        // same sample, starting from a cleared counter.
                        run_down   = 1'b1;
                        count_down = '0;
                    end else begin
                        mode_next  = MODE_UP;
                        count_next = '0;
                    end
                end else begin
                    count_next = count_bounce;
                end
            end
            MODE_DOWN:
            begin
                run_down   = 1'b1;
                count_down = count_reg;
            end
            MODE_HELD:
            begin
                if (count_hold >= hold_timeout) begin
                    count_next = '0;
                    event_next = EV_HOLDING;
                end else if (!level) begin
                    mode_next  = MODE_BOUNCE_UP;
                    count_next = '0;
                    event_next = EV_RELEASED;
                end else begin
                    count_next = count_hold;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        if (run_down) begin
            if (!level) begin
                mode_next  = MODE_BOUNCE_UP;
                count_next = '0;
                event_next = EV_RELEASED;
            end else begin
                if (qualified) begin
                    count_down = (count_down == '1) ? count_down
                                                    : count_down + TIMEOUT_W'(1);
                end
                if (count_down >= hold_timeout) begin
                    mode_next  = MODE_HELD;
                    count_next = '0;
                    event_next = EV_HELD;
                end else begin
                    mode_next  = MODE_DOWN;
                    count_next = count_down;
                end
            end
        end
    end

    assign result.event_code   = event_next;
    assign result.button_state = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_UP;
            count_reg      <= '0;
            prev_level_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            prev_level_reg <= level;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the button debouncer with hold events. A
// scoreboard class predicts the event and the next state for every sample
// word and compares each result word in order. Directed samples come first,
// followed by random press sessions under several timeout settings and
// handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import bde_pkg::*;

    localparam int HOLD_SKIP    = 16;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [CODE_W-1:0] {
        ST_UP          = 3'd0,
        ST_KEPT_UP     = 3'd1,
        ST_BOUNCE_DOWN = 3'd2,
        ST_DOWN        = 3'd3,
        ST_HELD        = 3'd4,
        ST_BOUNCE_UP   = 3'd5
    } btn_state_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_HELD     = 3'd3,
        EV_HOLDING  = 3'd4,
        EV_KEPT_UP  = 3'd5
    } btn_event_t;

    class debounce_scoreboard;
        btn_state_t           mode;
        logic [TIMEOUT_W-1:0] stable_count;
        logic                 last_level;
        logic [TIMEOUT_W-1:0] debounce_limit;
        logic [TIMEOUT_W-1:0] hold_limit;
        step_result_t         predicted_q[$];
        int                   errors;

        function new();
            mode           = ST_UP;
            stable_count   = '0;
            last_level     = 1'b0;
            debounce_limit = DEBOUNCE_TIMEOUT_RST;
            hold_limit     = HOLD_TIMEOUT_RST;
            errors         = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [TIMEOUT_W-1:0] value);
            if (idx == CFG_DEBOUNCE_TIMEOUT)
            begin
                debounce_limit = value;
            end
            else if (idx == CFG_HOLD_TIMEOUT)
            begin
                hold_limit = value;
            end
        endfunction

        function void enter_state(btn_state_t next_mode);
            mode         = next_mode;
            stable_count = '0;
        endfunction

        function void bump_count();
            if (stable_count != '1)
            begin
                stable_count++;
            end
        endfunction

        function btn_event_t advance_button(logic lv, logic [TICK_W-1:0] tk);
            logic prior;
            logic qualified;
            prior      = last_level;
            qualified  = ((tk % HOLD_SKIP) == 0);
            last_level = lv;
            if (mode == ST_UP)
            begin
                if (lv)
                begin
                    enter_state(ST_BOUNCE_DOWN);
                    return EV_PRESSED;
                end
                if (qualified)
                begin
                    bump_count();
                end
                if (stable_count >= hold_limit)
                begin
                    enter_state(ST_KEPT_UP);
                    return EV_KEPT_UP;
                end
                return EV_NONE;
            end
            if (mode == ST_KEPT_UP)
            begin
                if (lv)
                begin
                    enter_state(ST_BOUNCE_DOWN);
                    return EV_PRESSED;
                end
                return EV_NONE;
            end
            if (mode == ST_BOUNCE_DOWN || mode == ST_BOUNCE_UP)
            begin
                if (lv == prior)
                begin
                    bump_count();
                end
                else
                begin
                    stable_count = '0;
                end
                if (stable_count < debounce_limit)
                begin
                    return EV_NONE;
                end
                if (mode == ST_BOUNCE_UP)
                begin
                    enter_state(ST_UP);
                    return EV_NONE;
                end
                // A settled press falls straight into the down check below.
                enter_state(ST_DOWN);
            end
            if (mode == ST_DOWN)
            begin
                if (!lv)
                begin
                    enter_state(ST_BOUNCE_UP);
                    return EV_RELEASED;
                end
                if (qualified)
                begin
                    bump_count();
                end
                if (stable_count >= hold_limit)
                begin
                    enter_state(ST_HELD);
                    return EV_HELD;
                end
                return EV_NONE;
            end
            if (mode == ST_HELD)
            begin
                if (qualified)
                begin
                    bump_count();
                end
                // The repeat takes priority over a release in the same sample.
                if (stable_count >= hold_limit)
                begin
                    stable_count = '0;
                    return EV_HOLDING;
                end
                if (!lv)
                begin
                    enter_state(ST_BOUNCE_UP);
                    return EV_RELEASED;
                end
            end
            return EV_NONE;
        endfunction

        function void note_sample(logic lv, logic [TICK_W-1:0] tk);
            step_result_t r;
            r.event_code   = advance_button(lv, tk);
            r.button_state = mode;
            predicted_q.push_back(r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] word);
            step_result_t r;
            if (predicted_q.size() == 0)
            begin
                $error("result word %h arrived with no sample pending", word);
                errors++;
                return;
            end
            r = predicted_q.pop_front();
            if (word[CODE_W-1:0] !== r.event_code)
            begin
                $error("event_code mismatch: expected %0d, actual %0d",
                       r.event_code, word[CODE_W-1:0]);
                errors++;
            end
            if (word[2*CODE_W-1:CODE_W] !== r.button_state)
            begin
                $error("button_state mismatch: expected %0d, actual %0d",
                       r.button_state, word[2*CODE_W-1:CODE_W]);
                errors++;
            end
            if (word[M_DATA_W-1:2*CODE_W] !== '0)
            begin
                $error("pad mismatch: expected 0, actual %0d", word[M_DATA_W-1:2*CODE_W]);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;   // level[0], tick_count[16:1], zero[23:17]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;          // event_code[2:0], button_state[5:3], zero[7:6]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TIMEOUT_W-1:0]   cfg_data  = '0;

    debounce_scoreboard sb;
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int hold_off_cycles = 0;
    int samples_sent    = 0;
    int cycle_count     = 0;
    bit pause_request   = 1'b0;

    button_debounce_hold_events #(
        .HOLD_CHECK_SKIP(HOLD_SKIP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check every accepted word, then pick the next ready level.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
        if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offers one sample word and returns at the edge where it is taken.
    task automatic send_sample(input logic lv, input logic [TICK_W-1:0] tk);
        if (pause_request)
        begin
            pause_request = 1'b0;
            s_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (sb.pending() != 0);
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({tk, lv});
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_sample(lv, tk);
        samples_sent++;
    endtask

    // Stops offering and waits until every predicted word has been checked.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeouts(input logic [TIMEOUT_W-1:0] deb,
                                  input logic [TIMEOUT_W-1:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_TIMEOUT;
        cfg_data  <= deb;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_register(CFG_DEBOUNCE_TIMEOUT, deb);
        cfg_index <= CFG_HOLD_TIMEOUT;
        cfg_data  <= hold;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_register(CFG_HOLD_TIMEOUT, hold);
        cfg_valid <= 1'b0;
    endtask

    // At least half of the ticks qualify for hold counting.
    function automatic logic [TICK_W-1:0] next_tick();
        logic [TICK_W-1:0] tk;
        tk = TICK_W'($urandom);
        if ($urandom_range(1) == 1)
        begin
            tk = tk - TICK_W'(tk % HOLD_SKIP);
        end
        return tk;
    endfunction

    function automatic int run_length();
        int span;
        span = sb.debounce_limit + 3 * sb.hold_limit + 4;
        if (span > 60)
        begin
            span = 60;
        end
        return $urandom_range(span, 0);
    endfunction

    task automatic send_run(input logic lv, input int n);
        repeat (n) send_sample(lv, next_tick());
    endtask

    task automatic send_bounce(input logic first_lv);
        int  k;
        logic lv;
        k  = $urandom_range(4, 0);
        lv = first_lv;
        repeat (k)
        begin
            send_sample(lv, next_tick());
            lv = !lv;
        end
    endtask

    // Mostly complete press sessions with contact bounce, some pure noise.
    task automatic random_phase(input int n_items);
        int target;
        target = samples_sent + n_items;
        while (samples_sent < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(6, 1)) send_sample(1'($urandom_range(1)), next_tick());
            end
            else
            begin
                send_run(1'b0, run_length());
                send_bounce(1'b1);
                send_run(1'b1, run_length() + 1);
                send_bounce(1'b0);
            end
        end
    endtask

    task automatic directed_phase();
        write_timeouts(8'd2, 8'd2);
        send_sample(1'b0, 16'h0010);
        send_sample(1'b0, 16'h0000);
        send_sample(1'b0, 16'hFFFF);
        send_sample(1'b1, 16'h0005);
        send_sample(1'b0, 16'h0007);
        send_sample(1'b0, 16'h0009);
        // Press settles while the level is already low: released at once.
        send_sample(1'b0, 16'h000B);
        send_sample(1'b0, 16'h0001);
        send_sample(1'b0, 16'h0002);
        send_sample(1'b1, 16'h8000);
        send_sample(1'b1, 16'h7FFF);
        send_sample(1'b1, 16'h0010);
        send_sample(1'b1, 16'h0020);
        send_sample(1'b1, 16'hFFF0);
        send_sample(1'b1, 16'h1230);
        send_sample(1'b1, 16'h0001);
        send_sample(1'b0, 16'h0003);
        settle();
        write_timeouts(8'd0, 8'd0);
        send_sample(1'b0, 16'h5555);
        send_sample(1'b0, 16'h0001);
        send_sample(1'b1, 16'hAAAA);
        send_sample(1'b1, 16'hAAAA);
        send_sample(1'b1, 16'h0040);
        send_sample(1'b0, 16'h0041);
        settle();
        write_timeouts(8'd0, 8'd255);
        send_sample(1'b0, 16'h0050);
        send_sample(1'b0, 16'h0051);
        settle();
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_phase();

        write_timeouts(8'd3, 8'd4);
        random_phase(65);
        settle();

        write_timeouts(8'd1, 8'd2);
        src_idle_pct = 65;
        random_phase(65);
        settle();

        write_timeouts(8'd5, 8'd6);
        src_idle_pct   = 0;
        sink_stall_pct = 65;
        hold_off_cycles = 80;
        random_phase(65);
        settle();

        write_timeouts(8'd0, 8'd1);
        src_idle_pct   = 27;
        sink_stall_pct = 27;
        random_phase(65);
        settle();

        write_timeouts(8'd255, 8'd255);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_phase(40);
        settle();

        // Counters left running under the large timeouts meet smaller limits.
        write_timeouts(TIMEOUT_W'($urandom_range(8, 0)), TIMEOUT_W'($urandom_range(8, 0)));
        src_idle_pct   = 27;
        sink_stall_pct = 27;
        random_phase(35);
        pause_request = 1'b1;
        random_phase(35);
        settle();

        write_timeouts(DEBOUNCE_TIMEOUT_RST, 8'd7);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_phase(65);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bde_pkg.sv
rtl/bde_tick_qual.sv
rtl/bde_fsm.sv
rtl/button_debounce_hold_events.sv
dv/tb_top.sv
